@@ rtl/core/stpg_pkg.sv @@
// shared types and constants for the stepper step pulse generator
package stpg_pkg;

    localparam int DELAY_CFG_W = 16;
    localparam int DELAY_W     = 17;
    localparam int PROD_W      = 24;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // request kinds carried on tuser
    localparam logic REQ_VELOCITY = 1'b0;
    localparam logic REQ_TARGET   = 1'b1;

    // register select, paddr[2]
    localparam logic REG_MIN_DELAY = 1'b0;
    localparam logic REG_MAX_DELAY = 1'b1;

    // ceil(2^32 / 127) and ceil(2^32 / 255), exact for products below 2^24
    localparam logic [RECIP_W-1:0] RECIP_VEL = 26'd33818641;
    localparam logic [RECIP_W-1:0] RECIP_TGT = 26'd16843010;

    typedef struct packed {
        logic               req_type;
        logic signed [7:0]  velocity;
        logic [7:0]         speed;
        logic signed [31:0] target_position;
        logic [31:0]        now_us;
    } t_item;

    typedef struct packed {
        logic               step_pulse;
        logic               direction;
        logic signed [31:0] position;
    } t_res;

endpackage

@@ rtl/core/stepper_step_pulse_generator_core.sv @@
// Step/direction pulse generator core. Each input beat is one service call with the
// current microsecond time; each produces exactly one result beat with the step flag,
// the held direction level and the step position. The block accepts one beat per clock
// unless the output stalls; each result passes five registers: an input register, the
// speed-times-span multiplier, the reciprocal multiplier that divides by 127 or 255, the
// delay offset stage and the output register. A result held by m_axis_tready low freezes
// every stage and drops s_axis_tready until it leaves. Only the last stage touches the
// position and step-time state, so beats may follow each other in consecutive cycles.
// The user must write min_delay and max_delay through the APB port only while no beat is
// in flight; the block itself does not enforce this.
module stepper_step_pulse_generator_core
    import stpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // velocity[7:0], speed[15:8], target_position[47:16], now_us[79:48]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // step_pulse[0], direction[1], position[33:2], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic                   en;
    logic                   cfg_wr;
    logic [DELAY_CFG_W-1:0] r_min_delay;
    logic [DELAY_CFG_W-1:0] r_max_delay;
    logic                   r_in_valid;
    t_item                  r_in;
    t_item                  s_item;
    logic                   d_valid;
    t_item                  d_item;
    logic [DELAY_W-1:0]     d_delay;
    t_res                   res;
    logic signed [31:0]     cur_pos;
    logic                   r_out_valid;
    t_res                   r_out;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;

    always_comb begin
        s_item.req_type        = s_axis_tuser;
        s_item.velocity        = s_axis_tdata[7:0];
        s_item.speed           = s_axis_tdata[15:8];
        s_item.target_position = s_axis_tdata[47:16];
        s_item.now_us          = s_axis_tdata[79:48];
    end

    always_comb begin
        case (paddr[2])
            REG_MIN_DELAY: prdata = {{(APB_DATA_W-DELAY_CFG_W){1'b0}}, r_min_delay};
            REG_MAX_DELAY: prdata = {{(APB_DATA_W-DELAY_CFG_W){1'b0}}, r_max_delay};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delay <= '0;
            r_max_delay <= '1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MIN_DELAY: r_min_delay <= pwdata[DELAY_CFG_W-1:0];
                REG_MAX_DELAY: r_max_delay <= pwdata[DELAY_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_in_valid  <= s_axis_tvalid;
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in  <= s_item;
            r_out <= res;
        end
    end

    stpg_delay_map u_delay_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .i_min_delay (r_min_delay),
        .i_max_delay (r_max_delay),
        .o_valid     (d_valid),
        .o_item      (d_item),
        .o_delay     (d_delay)
    );

    stpg_step_ctrl u_step_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_item  (d_item),
        .i_delay (d_delay),
        .o_res   (res),
        .o_pos   (cur_pos)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-34){1'b0}}, r_out.position,
                            r_out.direction, r_out.step_pulse};

`ifndef SYNTHESIS
    a_step_moves_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && d_valid && res.step_pulse) |=>
        (cur_pos == $past(cur_pos) + 32'sd1) || (cur_pos == $past(cur_pos) - 32'sd1))
        else $error("step did not move position by one");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(en && d_valid && res.step_pulse)) |=> cur_pos == $past(cur_pos))
        else $error("position changed without a step");

    a_dir_matches_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_valid && res.step_pulse) |->
        (res.direction == (res.position == cur_pos + 32'sd1)))
        else $error("direction level disagrees with step");
`endif

endmodule

@@ rtl/core/stpg_delay_map.sv @@
// three-stage map from velocity or speed input to step delay
module stpg_delay_map
    import stpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_item                  i_item,
    input  logic [DELAY_CFG_W-1:0] i_min_delay,
    input  logic [DELAY_CFG_W-1:0] i_max_delay,
    output logic                   o_valid,
    output t_item                  o_item,
    output logic [DELAY_W-1:0]     o_delay
);

    logic [8:0]             vel_ext;
    logic [8:0]             vel_mag;
    logic [8:0]             mult_m;
    logic [16:0]            span;
    logic                   span_neg;
    logic [15:0]            span_abs;
    logic [24:0]            prod_a;
    logic [RECIP_W-1:0]     recip;
    logic [49:0]            prod_b;
    logic [17:0]            sum_c;
    logic [17:0]            dif_c;
    logic [DELAY_W-1:0]     n_delay;

    logic                   r_a_valid;
    t_item                  r_a_item;
    logic                   r_a_neg;
    logic [PROD_W-1:0]      r_p;
    logic                   r_b_valid;
    t_item                  r_b_item;
    logic                   r_b_neg;
    logic [DELAY_W-1:0]     r_q;
    logic                   r_c_valid;
    t_item                  r_c_item;
    logic [DELAY_W-1:0]     r_delay;

    // magnitude times span
    always_comb begin
        vel_ext  = {i_item.velocity[7], i_item.velocity};
        vel_mag  = i_item.velocity[7] ? (~vel_ext + 9'd1) : vel_ext;
        mult_m   = (i_item.req_type == REQ_TARGET) ? {1'b0, i_item.speed} : vel_mag;
        span     = {1'b0, i_max_delay} - {1'b0, i_min_delay};
        span_neg = span[16];
        span_abs = span_neg ? 16'(~span + 17'd1) : span[15:0];
        prod_a   = mult_m * span_abs;
    end

    // divide by 127 or 255 through reciprocal
    always_comb begin
        recip  = (r_a_item.req_type == REQ_TARGET) ? RECIP_TGT : RECIP_VEL;
        prod_b = r_p * recip;
    end

    // offset by min delay, clamp at zero
    always_comb begin
        sum_c = {2'b00, i_min_delay} + {1'b0, r_q};
        dif_c = {2'b00, i_min_delay} - {1'b0, r_q};
        if (r_b_neg) begin
            n_delay = dif_c[17] ? '0 : dif_c[DELAY_W-1:0];
        end else begin
            n_delay = sum_c[DELAY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_a_neg  <= span_neg;
            r_p      <= prod_a[PROD_W-1:0];
            r_b_item <= r_a_item;
            r_b_neg  <= r_a_neg;
            r_q      <= prod_b[RECIP_SHIFT+DELAY_W-1:RECIP_SHIFT];
            r_c_item <= r_b_item;
            r_delay  <= n_delay;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;
    assign o_delay = r_delay;

endmodule

@@ rtl/core/stpg_step_ctrl.sv @@
// step decision and position, direction and step time state
module stpg_step_ctrl
    import stpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_item              i_item,
    input  logic [DELAY_W-1:0] i_delay,
    output t_res               o_res,
    output logic signed [31:0] o_pos
);

    logic               r_dir;
    logic signed [31:0] r_pos;
    logic [31:0]        r_last;
    logic               n_dir;
    logic signed [31:0] n_pos;
    logic [31:0]        elapsed;
    logic               due;
    logic               fire;
    logic               fwd;

    always_comb begin
        elapsed = i_item.now_us - r_last;
        due     = elapsed >= {{(32-DELAY_W){1'b0}}, i_delay};
        case (i_item.req_type)
            REQ_VELOCITY: begin
                fire = (i_item.velocity != 8'sd0) && due;
                fwd  = !i_item.velocity[7];
            end
            REQ_TARGET: begin
                fire = (i_item.target_position != r_pos) && due;
                fwd  = i_item.target_position > r_pos;
            end
            default: begin
                fire = 1'b0;
                fwd  = 1'b0;
            end
        endcase
        n_dir = fire ? fwd : r_dir;
        if (!fire) begin
            n_pos = r_pos;
        end else if (fwd) begin
            n_pos = r_pos + 32'sd1;
        end else begin
            n_pos = r_pos - 32'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= 1'b0;
            r_pos  <= '0;
            r_last <= '0;
        end else if (i_en && i_valid) begin
            r_dir <= n_dir;
            r_pos <= n_pos;
            if (fire) begin
                r_last <= i_item.now_us;
            end
        end
    end

    assign o_res = '{step_pulse: fire, direction: n_dir, position: n_pos};
    assign o_pos = r_pos;

endmodule
